/* design/mts_pkg.sv */
// Shared types and constants for the midtones transfer stretch pipeline.
// No dependencies.
package mts_pkg;

  localparam int PIXEL_BITS_DEF = 16;
  localparam int CFG_IDX_BITS   = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SHADOW    = 2'd0,
    CFG_HIGHLIGHT = 2'd1,
    CFG_MIDTONES  = 2'd2
  } cfg_idx_t;

  // Control that travels with each beat down the pipeline.
  typedef struct packed {
    logic valid;
    logic byp;
  } ctrl_t;

endpackage

/* design/mts_div_cell.sv */
// One restoring divide step: one quotient bit per cell, registered.
// Depends on mts_pkg.
module mts_div_cell import mts_pkg::*; #(
  parameter int QW = PIXEL_BITS_DEF,
  parameter int W  = PIXEL_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  ctrl_t         ctrl_i,
  input  logic [QW-1:0] bval_i,
  input  logic [QW-1:0] q_i,
  input  logic [W-1:0]  r_i,
  input  logic [W-1:0]  a_i,
  input  logic [W-1:0]  d_i,
  output ctrl_t         ctrl_o,
  output logic [QW-1:0] bval_o,
  output logic [QW-1:0] q_o,
  output logic [W-1:0]  r_o,
  output logic [W-1:0]  a_o,
  output logic [W-1:0]  d_o
);

  logic [W-1:0]  room;
  logic          take;
  ctrl_t         ctrl_r;
  logic [QW-1:0] bval_r, q_r, q_nxt;
  logic [W-1:0]  r_r, a_r, d_r, r_nxt;

  // r < d always holds, so the doubled remainder fits in W bits.
  always_comb begin
    room  = d_i - r_i;
    take  = (r_i >= room);
    r_nxt = take ? (r_i - room) : {r_i[W-2:0], 1'b0};
    q_nxt = {q_i[QW-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else begin
      ctrl_r <= ctrl_i;
    end
  end

  always_ff @(posedge clk) begin
    bval_r <= bval_i;
    q_r    <= q_nxt;
    r_r    <= r_nxt;
    a_r    <= a_i;
    d_r    <= d_i;
  end

  assign ctrl_o = ctrl_r;
  assign bval_o = bval_r;
  assign q_o    = q_r;
  assign r_o    = r_r;
  assign a_o    = a_r;
  assign d_o    = d_r;

endmodule

/* design/mts_div_chain.sv */
// Row of QW divide cells giving floor(a * 2^QW / d) and its remainder.
// Depends on mts_pkg and mts_div_cell.
module mts_div_chain import mts_pkg::*; #(
  parameter int QW = PIXEL_BITS_DEF,
  parameter int W  = PIXEL_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  ctrl_t         ctrl_i,
  input  logic [QW-1:0] bval_i,
  input  logic [W-1:0]  a_i,
  input  logic [W-1:0]  d_i,
  output ctrl_t         ctrl_o,
  output logic [QW-1:0] bval_o,
  output logic [QW-1:0] q_o,
  output logic [W-1:0]  r_o,
  output logic [W-1:0]  a_o
);

  ctrl_t         ctrl_s [0:QW];
  logic [QW-1:0] bval_s [0:QW];
  logic [QW-1:0] q_s    [0:QW];
  logic [W-1:0]  r_s    [0:QW];
  logic [W-1:0]  a_s    [0:QW];
  logic [W-1:0]  d_s    [0:QW];

  assign ctrl_s[0] = ctrl_i;
  assign bval_s[0] = bval_i;
  assign q_s[0]    = '0;
  assign r_s[0]    = a_i;
  assign a_s[0]    = a_i;
  assign d_s[0]    = d_i;

  for (genvar k = 0; k < QW; k++) begin : g_cell
    mts_div_cell #(.QW(QW), .W(W)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl_i (ctrl_s[k]),
      .bval_i (bval_s[k]),
      .q_i    (q_s[k]),
      .r_i    (r_s[k]),
      .a_i    (a_s[k]),
      .d_i    (d_s[k]),
      .ctrl_o (ctrl_s[k+1]),
      .bval_o (bval_s[k+1]),
      .q_o    (q_s[k+1]),
      .r_o    (r_s[k+1]),
      .a_o    (a_s[k+1]),
      .d_o    (d_s[k+1])
    );
  end

  assign ctrl_o = ctrl_s[QW];
  assign bval_o = bval_s[QW];
  assign q_o    = q_s[QW];
  assign r_o    = r_s[QW];
  assign a_o    = a_s[QW];

endmodule

/* design/midtones_transfer_pixel_stretch.sv */
// Top level of the midtones transfer stretch: clip, rescale, midtones curve.
// Depends on mts_pkg, mts_div_chain (and through it mts_div_cell).
//
//   channel | ports                                   | beat taken when
//   --------+-----------------------------------------+--------------------
//   input   | start, busy, in_pixel_in                | start && !busy
//   result  | out_valid, out_pixel_out                | out_valid (1 cycle)
//   config  | cfg_we, cfg_index, cfg_wdata            | cfg_we
//
// One pixel per clock; each result passes stage A, the first row of PIXEL_BITS
// divide cells, stages X, M1 and M2, the second row and the output register.
// busy is never raised: every stage advances every cycle.
// Synchronous active-low reset clears beat valid bits and loads register
// defaults (shadow 0, highlight full scale, midtones one half).
// The receiver cannot stall; out_valid lasts exactly one cycle per beat.
module midtones_transfer_pixel_stretch import mts_pkg::*; #(
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [PIXEL_BITS-1:0]   in_pixel_in,
  output logic                    out_valid,
  output logic [PIXEL_BITS-1:0]   out_pixel_out,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [PIXEL_BITS-1:0]   cfg_wdata
);

  localparam int P  = PIXEL_BITS;
  localparam int W2 = 2 * P + 1;
  localparam logic [P-1:0] FULL = {P{1'b1}};
  localparam logic [P-1:0] HALF = {1'b1, {(P-1){1'b0}}};

  // Configuration registers.
  logic [P-1:0] shadow_r, highlight_r, mid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shadow_r    <= '0;
      highlight_r <= FULL;
      mid_r       <= HALF;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SHADOW:    shadow_r    <= cfg_wdata;
        CFG_HIGHLIGHT: highlight_r <= cfg_wdata;
        CFG_MIDTONES:  mid_r       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;
  logic accept;
  assign accept = start && !busy;

  // Stage A: clip test and rescale operands.
  ctrl_t        a_ctrl_r, a_ctrl_nxt;
  logic [P-1:0] a_bval_r, a_bval_nxt, a_num_r, a_num_nxt, a_den_r, a_den_nxt;

  always_comb begin
    a_ctrl_nxt.valid = accept;
    a_ctrl_nxt.byp   = (in_pixel_in <= shadow_r) || (in_pixel_in >= highlight_r);
    a_bval_nxt       = (in_pixel_in <= shadow_r) ? '0 : FULL;
    a_num_nxt        = in_pixel_in - shadow_r;
    a_den_nxt        = highlight_r - shadow_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) a_ctrl_r <= '0;
    else        a_ctrl_r <= a_ctrl_nxt;
  end

  always_ff @(posedge clk) begin
    a_bval_r <= a_bval_nxt;
    a_num_r  <= a_num_nxt;
    a_den_r  <= a_den_nxt;
  end

  // First divider row: x = floor((p - s) * F / (h - s)).
  ctrl_t        d1_ctrl;
  logic [P-1:0] d1_bval, d1_q, d1_r, d1_a;

  mts_div_chain #(.QW(P), .W(P)) u_div_rescale (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl_i (a_ctrl_r),
    .bval_i (a_bval_r),
    .a_i    (a_num_r),
    .d_i    (a_den_r),
    .ctrl_o (d1_ctrl),
    .bval_o (d1_bval),
    .q_o    (d1_q),
    .r_o    (d1_r),
    .a_o    (d1_a)
  );

  // Stage X: correct the quotient for F = 2^P - 1, catch early exits.
  ctrl_t        x_ctrl_r, x_ctrl_nxt;
  logic [P-1:0] x_r, x_nxt, x_bval_r, x_bval_nxt;

  always_comb begin
    x_nxt      = (d1_r < d1_a) ? (d1_q - 1'b1) : d1_q;
    x_ctrl_nxt = d1_ctrl;
    x_bval_nxt = d1_bval;
    if (!d1_ctrl.byp) begin
      if (x_nxt == '0) begin
        x_ctrl_nxt.byp = 1'b1;
        x_bval_nxt     = '0;
      end else if (x_nxt == FULL) begin
        x_ctrl_nxt.byp = 1'b1;
        x_bval_nxt     = FULL;
      end else if (mid_r == HALF) begin
        x_ctrl_nxt.byp = 1'b1;
        x_bval_nxt     = x_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) x_ctrl_r <= '0;
    else        x_ctrl_r <= x_ctrl_nxt;
  end

  always_ff @(posedge clk) begin
    x_r      <= x_nxt;
    x_bval_r <= x_bval_nxt;
  end

  // Stage M1: the two products of the curve.
  ctrl_t          m1_ctrl_r;
  logic [P-1:0]   m1_x_r, m1_bval_r;
  logic [2*P-1:0] m1_num_r, m1_part_r;

  always_ff @(posedge clk) begin
    if (!rst_n) m1_ctrl_r <= '0;
    else        m1_ctrl_r <= x_ctrl_r;
  end

  always_ff @(posedge clk) begin
    m1_num_r  <= x_r * (FULL - mid_r);
    m1_part_r <= mid_r * (FULL - x_r);
    m1_x_r    <= x_r;
    m1_bval_r <= x_bval_r;
  end

  // Stage M2: form the denominator; guard zero and num >= den.
  ctrl_t         m2_ctrl_r, m2_ctrl_nxt;
  logic [P-1:0]  m2_bval_r, m2_bval_nxt;
  logic [W2-1:0] m2_num_r, m2_den_r, den_sum;

  always_comb begin
    den_sum     = {1'b0, m1_num_r} + {1'b0, m1_part_r};
    m2_ctrl_nxt = m1_ctrl_r;
    m2_bval_nxt = m1_bval_r;
    if (!m1_ctrl_r.byp) begin
      if (den_sum == '0) begin
        m2_ctrl_nxt.byp = 1'b1;
        m2_bval_nxt     = m1_x_r;
      end else if ({1'b0, m1_num_r} >= den_sum) begin
        m2_ctrl_nxt.byp = 1'b1;
        m2_bval_nxt     = FULL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) m2_ctrl_r <= '0;
    else        m2_ctrl_r <= m2_ctrl_nxt;
  end

  always_ff @(posedge clk) begin
    m2_bval_r <= m2_bval_nxt;
    m2_num_r  <= {1'b0, m1_num_r};
    m2_den_r  <= den_sum;
  end

  // Second divider row: y = floor(num * F / den).
  ctrl_t         d2_ctrl;
  logic [P-1:0]  d2_bval, d2_q;
  logic [W2-1:0] d2_r, d2_a;

  mts_div_chain #(.QW(P), .W(W2)) u_div_curve (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl_i (m2_ctrl_r),
    .bval_i (m2_bval_r),
    .a_i    (m2_num_r),
    .d_i    (m2_den_r),
    .ctrl_o (d2_ctrl),
    .bval_o (d2_bval),
    .q_o    (d2_q),
    .r_o    (d2_r),
    .a_o    (d2_a)
  );

  // Output register: pick the early-exit value or the corrected quotient.
  logic         out_valid_r;
  logic [P-1:0] out_pixel_r, out_pixel_nxt;

  always_comb begin
    if (d2_ctrl.byp)      out_pixel_nxt = d2_bval;
    else if (d2_r < d2_a) out_pixel_nxt = d2_q - 1'b1;
    else                  out_pixel_nxt = d2_q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= d2_ctrl.valid;
  end

  always_ff @(posedge clk) begin
    out_pixel_r <= out_pixel_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_out = out_pixel_r;

`ifndef NO_ASSERTIONS
  a_rescale_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (a_ctrl_r.valid && !a_ctrl_r.byp) |-> (a_num_r < a_den_r))
    else $error("rescale operand not below span");

  a_x_interior: assert property (@(posedge clk) disable iff (!rst_n)
    (x_ctrl_r.valid && !x_ctrl_r.byp) |-> (x_r != '0 && x_r != FULL))
    else $error("curve entered with x at an end");

  a_curve_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (m2_ctrl_r.valid && !m2_ctrl_r.byp) |-> (m2_num_r < m2_den_r))
    else $error("curve numerator not below denominator");
`endif

endmodule
